[hw/rtl/thp_pkg.sv]
// ----------------------------------------------------------------------------
// thp_pkg
// shared constants, register indexes and arithmetic helpers of the
// temperature / pressure / humidity compensation core
// ----------------------------------------------------------------------------
`default_nettype none

package thp_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_TEMP_COEF = 3'd0,
      CSR_PRESS_LO  = 3'd1,
      CSR_PRESS_HI  = 3'd2,
      CSR_PRESS_P9  = 3'd3,
      CSR_HUM_COEF  = 3'd4
   } csr_idx_type;

   // pipeline depths, counted in register stages from the input transaction
   localparam int TEMP_TF_LAT = 4;   // fine temperature
   localparam int TEMP_TC_LAT = 5;   // centidegrees
   localparam int HUM_LAT     = 11;  // humidity, after fine temperature
   localparam int DIV_STAGES  = 64;  // one quotient bit per stage
   localparam int PRESS_LAT   = 7 + DIV_STAGES + 7;
   localparam int TOTAL_LAT   = TEMP_TF_LAT + PRESS_LAT;

   // compensation constants
   localparam logic [33:0] PRESS_OFFSET = 34'd128000;
   localparam logic [20:0] PRESS_FULL   = 21'd1048576;
   localparam logic [11:0] PRESS_SCALE  = 12'd3125;
   localparam logic [31:0] HUM_OFFSET   = 32'd76800;
   localparam logic [31:0] HUM_ROUND_A  = 32'd16384;
   localparam logic [31:0] HUM_ROUND_B  = 32'd32768;
   localparam logic [31:0] HUM_BIAS     = 32'd2097152;
   localparam logic [31:0] HUM_ROUND_C  = 32'd8192;
   localparam logic [31:0] HUM_CAP      = 32'd419430400;
   localparam logic [16:0] HUM_CAP_OUT  = 17'd102400;
   localparam logic [31:0] TEMP_ROUND   = 32'd128;
   localparam logic [63:0] PRESS_BIAS47 = 64'h0000_8000_0000_0000;

   // one stage of the restoring divider
   typedef struct packed {
      logic [30:0] rem;
      logic [63:0] nq;
      logic [30:0] dvs;
      logic        neg;
      logic        invalid;
   } div_stage_type;

   function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
      return 64'($signed(x) >>> n);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/thp_temp.sv]
// ----------------------------------------------------------------------------
// thp_temp
// temperature compensation pipeline: fine temperature and centidegrees
// ----------------------------------------------------------------------------
`default_nettype none

module thp_temp
   import thp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [19:0] raw_temperature,
   input  wire logic [47:0] temp_coef,
   output logic      [31:0] tf,
   output logic      [31:0] tc
);

   logic [31:0] t1_ext, t2_ext, t3_ext;
   logic [31:0] x1_in, x1_ff, d_in, d_ff;
   logic [31:0] m1_in, m1_ff, dd_in, dd_ff;
   logic [31:0] v1_in, v1_ff, v2p_in, v2p_ff;
   logic [31:0] tf_in, tf_ff, tc_in, tc_ff;

   assign t1_ext = {16'b0, temp_coef[15:0]};
   assign t2_ext = {{16{temp_coef[31]}}, temp_coef[31:16]};
   assign t3_ext = {{16{temp_coef[47]}}, temp_coef[47:32]};

   assign x1_in  = {15'b0, raw_temperature[19:3]} - {15'b0, temp_coef[15:0], 1'b0};
   assign d_in   = {16'b0, raw_temperature[19:4]} - t1_ext;
   assign m1_in  = x1_ff * t2_ext;
   assign dd_in  = d_ff * d_ff;
   assign v1_in  = asr32(m1_ff, 11);
   assign v2p_in = asr32(dd_ff, 12) * t3_ext;
   assign tf_in  = v1_ff + asr32(v2p_ff, 14);
   // tf * 5 as shift and add
   assign tc_in  = asr32({tf_ff[29:0], 2'b0} + tf_ff + TEMP_ROUND, 8);

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff  <= x1_in;
         d_ff   <= d_in;
         m1_ff  <= m1_in;
         dd_ff  <= dd_in;
         v1_ff  <= v1_in;
         v2p_ff <= v2p_in;
         tf_ff  <= tf_in;
         tc_ff  <= tc_in;
      end
   end

   assign tf = tf_ff;
   assign tc = tc_ff;

endmodule

`default_nettype wire

[hw/rtl/thp_hum.sv]
// ----------------------------------------------------------------------------
// thp_hum
// humidity compensation pipeline, clamped Q22.10 result
// ----------------------------------------------------------------------------
`default_nettype none

module thp_hum
   import thp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] tf,
   input  wire logic [15:0] raw_humidity,
   input  wire logic [63:0] hum_coef,
   output logic      [16:0] humidity
);

   logic [31:0] h1_ext, h2_ext, h3_ext, h4_sh, h5_ext, h6_ext;
   logic [31:0] v_in, v_ff;
   logic [15:0] ah1_ff, ah2_ff;
   logic [31:0] m5_in, m5_ff, m6_in, m6_ff, m3_in, m3_ff;
   logic [31:0] a_in, a3_ff, a4_ff, a5_ff, a6_ff, a7_ff;
   logic [31:0] b_in, b_ff, c_in, c_ff;
   logic [31:0] bc_in, bc_ff, e_in, e_ff, eh_in, eh_ff, f_in, f_ff;
   logic [31:0] vv_in, vv_ff, vv9_ff, vv10_ff, g, gg_in, gg_ff, k_in, k_ff;
   logic [31:0] v2;
   logic [16:0] hum_in, hum_ff;

   assign h1_ext = {24'b0, hum_coef[7:0]};
   assign h2_ext = {{16{hum_coef[23]}}, hum_coef[23:8]};
   assign h3_ext = {24'b0, hum_coef[31:24]};
   assign h4_sh  = {hum_coef[43:32], 20'b0};
   assign h5_ext = {{20{hum_coef[55]}}, hum_coef[55:44]};
   assign h6_ext = {{24{hum_coef[63]}}, hum_coef[63:56]};

   assign v_in   = tf - HUM_OFFSET;
   assign m5_in  = v_ff * h5_ext;
   assign m6_in  = v_ff * h6_ext;
   assign m3_in  = v_ff * h3_ext;
   assign a_in   = asr32({2'b0, ah2_ff, 14'b0} - h4_sh - m5_ff + HUM_ROUND_A, 15);
   assign b_in   = asr32(m6_ff, 10);
   assign c_in   = asr32(m3_ff, 11) + HUM_ROUND_B;
   assign bc_in  = b_ff * c_ff;
   assign e_in   = asr32(bc_ff, 10) + HUM_BIAS;
   assign eh_in  = e_ff * h2_ext;
   assign f_in   = asr32(eh_ff + HUM_ROUND_C, 14);
   assign vv_in  = a7_ff * f_ff;
   assign g      = asr32(vv_ff, 15);
   assign gg_in  = g * g;
   assign k_in   = asr32(gg_ff, 7) * h1_ext;
   assign v2     = vv10_ff - asr32(k_ff, 4);

   // clamp to 0..cap before the final shift
   always_comb begin
      if (v2[31]) begin
         hum_in = '0;
      end else if (v2 > HUM_CAP) begin
         hum_in = HUM_CAP_OUT;
      end else begin
         hum_in = v2[28:12];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff    <= v_in;
         ah1_ff  <= raw_humidity;
         m5_ff   <= m5_in;
         m6_ff   <= m6_in;
         m3_ff   <= m3_in;
         ah2_ff  <= ah1_ff;
         a3_ff   <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         a4_ff   <= a3_ff;
         bc_ff   <= bc_in;
         a5_ff   <= a4_ff;
         e_ff    <= e_in;
         a6_ff   <= a5_ff;
         eh_ff   <= eh_in;
         a7_ff   <= a6_ff;
         f_ff    <= f_in;
         vv_ff   <= vv_in;
         gg_ff   <= gg_in;
         vv9_ff  <= vv_ff;
         k_ff    <= k_in;
         vv10_ff <= vv9_ff;
         hum_ff  <= hum_in;
      end
   end

   assign humidity = hum_ff;

endmodule

`default_nettype wire

[hw/rtl/thp_press.sv]
// ----------------------------------------------------------------------------
// thp_press
// pressure compensation pipeline with a 64-stage signed divider
// ----------------------------------------------------------------------------
`default_nettype none

module thp_press
   import thp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] tf,
   input  wire logic [19:0] raw_pressure,
   input  wire logic [63:0] press_lo,
   input  wire logic [63:0] press_hi,
   input  wire logic [15:0] press_p9,
   output logic      [31:0] pressure,
   output logic             invalid
);

   logic        [15:0] p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

   // front section
   logic signed [33:0] w1_in, w1_ff;
   logic        [19:0] ap1_ff, ap2_ff, ap3_ff, ap4_ff;
   logic signed [67:0] sq_full;
   logic        [63:0] sq_ff;
   logic signed [49:0] m5_in, m5_ff, m5b_ff, m2_in, m2_ff, m2b_ff;
   logic signed [48:0] a6l_in, a6l_ff, a3l_in, a3l_ff;
   logic        [31:0] a6h_in, a6h_ff, a3h_in, a3h_ff;
   logic        [63:0] w2_in, w2_ff, w1b, x_in, x_ff;
   logic        [20:0] p0;
   logic        [63:0] n0_in, n0_ff;
   logic        [47:0] xl_in, xl_ff;
   logic        [31:0] xh_in, xh_ff;
   logic        [63:0] wsum;
   logic signed [30:0] w1c_ff, w1c7_ff;
   logic        [43:0] nl_in, nl_ff;
   logic        [31:0] nh_in, nh_ff;
   logic        [63:0] num_in, num_ff;
   div_stage_type      div0_in;
   div_stage_type      div_ff [DIV_STAGES];

   // back section
   logic        [63:0] q_in, q_ff, q2_ff, q3_ff, q4_ff, q5_ff, q6_ff;
   logic        [63:0] s_ff;
   logic signed [48:0] p8l_in, p8l_ff, l9_in, l9_ff;
   logic        [31:0] p8h_in, p8h_ff, h9_in, h9_ff;
   logic        [63:0] sll_in, sll_ff, ss_in, ss_ff;
   logic        [31:0] slh_in, slh_ff;
   logic        [63:0] w2b_in, w2b_ff, w2b4_ff, w2b5_ff, w2b6_ff, w1d_in, w1d_ff;
   logic        [63:0] res;
   logic        [6:1]  inv_ff;
   logic        [31:0] pr_in, pr_ff;
   logic               inv_out_ff;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type o;
      logic [31:0]   t;
      o = s;
      t = {s.rem, s.nq[63]};
      if (t >= {1'b0, s.dvs}) begin
         o.rem = 31'(t - {1'b0, s.dvs});
         o.nq  = {s.nq[62:0], 1'b1};
      end else begin
         o.rem = t[30:0];
         o.nq  = {s.nq[62:0], 1'b0};
      end
      return o;
   endfunction

   assign p1 = press_lo[15:0];
   assign p2 = press_lo[31:16];
   assign p3 = press_lo[47:32];
   assign p4 = press_lo[63:48];
   assign p5 = press_hi[15:0];
   assign p6 = press_hi[31:16];
   assign p7 = press_hi[47:32];
   assign p8 = press_hi[63:48];
   assign p9 = press_p9;

   // 1: offset fine temperature
   assign w1_in   = {{2{tf[31]}}, tf} - PRESS_OFFSET;
   // 2: square and the linear terms
   assign sq_full = w1_ff * w1_ff;
   assign m5_in   = w1_ff * p5;
   assign m2_in   = w1_ff * p2;
   // 3: square times coefficients, split into 32-bit halves
   assign a6l_in  = $signed({1'b0, sq_ff[31:0]}) * p6;
   assign a6h_in  = sq_ff[63:32] * {{16{p6[15]}}, p6};
   assign a3l_in  = $signed({1'b0, sq_ff[31:0]}) * p3;
   assign a3h_in  = sq_ff[63:32] * {{16{p3[15]}}, p3};
   // 4: gather terms
   assign w2_in   = {{15{a6l_ff[48]}}, a6l_ff} + {a6h_ff, 32'b0}
                  + {m5b_ff[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
   assign w1b     = asr64({{15{a3l_ff[48]}}, a3l_ff} + {a3h_ff, 32'b0}, 8)
                  + {{2{m2b_ff[49]}}, m2b_ff, 12'b0};
   assign x_in    = PRESS_BIAS47 + w1b;
   // 5: times p1, and the numerator before scaling
   assign xl_in   = x_ff[31:0] * p1;
   assign xh_in   = x_ff[63:32] * {16'b0, p1};
   assign p0      = PRESS_FULL - {1'b0, ap4_ff};
   assign n0_in   = {12'b0, p0, 31'b0} - w2_ff;
   // 6: divisor and scaled numerator halves
   assign wsum    = {16'b0, xl_ff} + {xh_ff, 32'b0};
   assign nl_in   = n0_ff[31:0] * PRESS_SCALE;
   assign nh_in   = n0_ff[63:32] * {20'b0, PRESS_SCALE};
   // 7: numerator
   assign num_in  = {20'b0, nl_ff} + {nh_ff, 32'b0};

   // 8: magnitudes and quotient sign
   always_comb begin
      div0_in.rem     = '0;
      div0_in.nq      = num_ff[63] ? (64'd0 - num_ff) : num_ff;
      div0_in.dvs     = w1c7_ff[30] ? (31'd0 - w1c7_ff) : w1c7_ff;
      div0_in.neg     = num_ff[63] ^ w1c7_ff[30];
      div0_in.invalid = (w1c7_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff   <= w1_in;
         ap1_ff  <= raw_pressure;
         sq_ff   <= sq_full[63:0];
         m5_ff   <= m5_in;
         m2_ff   <= m2_in;
         ap2_ff  <= ap1_ff;
         a6l_ff  <= a6l_in;
         a6h_ff  <= a6h_in;
         a3l_ff  <= a3l_in;
         a3h_ff  <= a3h_in;
         m5b_ff  <= m5_ff;
         m2b_ff  <= m2_ff;
         ap3_ff  <= ap2_ff;
         w2_ff   <= w2_in;
         x_ff    <= x_in;
         ap4_ff  <= ap3_ff;
         xl_ff   <= xl_in;
         xh_ff   <= xh_in;
         n0_ff   <= n0_in;
         w1c_ff  <= wsum[63:33];
         nl_ff   <= nl_in;
         nh_ff   <= nh_in;
         num_ff  <= num_in;
         w1c7_ff <= w1c_ff;
         div_ff[0] <= div_step(div0_in);
         for (int k = 1; k < DIV_STAGES; k++) begin
            div_ff[k] <= div_step(div_ff[k-1]);
         end
      end
   end

   // back end: sign, then the second-order correction terms
   assign q_in   = div_ff[DIV_STAGES-1].neg ? (64'd0 - div_ff[DIV_STAGES-1].nq)
                                            : div_ff[DIV_STAGES-1].nq;
   assign p8l_in = $signed({1'b0, q_ff[31:0]}) * p8;
   assign p8h_in = q_ff[63:32] * {{16{p8[15]}}, p8};
   assign sll_in = s_ff[31:0] * s_ff[31:0];
   assign slh_in = s_ff[31:0] * s_ff[63:32];
   assign w2b_in = asr64({{15{p8l_ff[48]}}, p8l_ff} + {p8h_ff, 32'b0}, 19);
   assign ss_in  = sll_ff + {slh_ff[30:0], 1'b0, 32'b0};
   assign l9_in  = $signed({1'b0, ss_ff[31:0]}) * p9;
   assign h9_in  = ss_ff[63:32] * {{16{p9[15]}}, p9};
   assign w1d_in = asr64({{15{l9_ff[48]}}, l9_ff} + {h9_ff, 32'b0}, 25);
   assign res    = asr64(q6_ff + w1d_ff + w2b6_ff, 8) + {{44{p7[15]}}, p7, 4'b0};
   assign pr_in  = inv_ff[6] ? '0 : res[31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff      <= q_in;
         inv_ff[1] <= div_ff[DIV_STAGES-1].invalid;
         s_ff      <= asr64(q_ff, 13);
         p8l_ff    <= p8l_in;
         p8h_ff    <= p8h_in;
         q2_ff     <= q_ff;
         sll_ff    <= sll_in;
         slh_ff    <= slh_in;
         w2b_ff    <= w2b_in;
         q3_ff     <= q2_ff;
         ss_ff     <= ss_in;
         w2b4_ff   <= w2b_ff;
         q4_ff     <= q3_ff;
         l9_ff     <= l9_in;
         h9_ff     <= h9_in;
         w2b5_ff   <= w2b4_ff;
         q5_ff     <= q4_ff;
         w1d_ff    <= w1d_in;
         w2b6_ff   <= w2b5_ff;
         q6_ff     <= q5_ff;
         inv_ff[6:2] <= inv_ff[5:1];
         pr_ff      <= pr_in;
         inv_out_ff <= inv_ff[6];
      end
   end

   assign pressure = pr_ff;
   assign invalid  = inv_out_ff;

endmodule

`default_nettype wire

[hw/rtl/thp_sensor_compensation_core.sv]
// ----------------------------------------------------------------------------
// thp_sensor_compensation_core
// integer compensation of raw temperature, pressure and humidity samples
// ----------------------------------------------------------------------------
// Takes one raw temperature/pressure/humidity triple per clock and returns
// centidegrees, Q24.8 pascals and clamped Q22.10 %RH with a flag that marks a
// zero pressure divisor (pressure then reads 0). The datapath is one lock-step
// pipeline of TOTAL_LAT (82) register stages: 4 for the fine temperature and 78
// for pressure, whose 64-bit signed division resolves one quotient bit per
// stage. A new transaction is taken every cycle while the result side keeps up;
// the whole pipeline holds while the last stage carries a result that is not
// taken, so nothing is dropped or repeated. Coefficients come from five csr
// registers that reset to zero and must be written while idle (not enforced).
`default_nettype none

module thp_sensor_compensation_core
   import thp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // raw_temperature, raw_pressure, raw_humidity
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [87:0] rsp_tdata,  // temperature_centi, pressure_q24_8,
                                        // humidity_q22_10, zero fill
   output logic      [0:0]  rsp_tuser,  // pressure_invalid
   // coefficient write port
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int TC_DLY  = TOTAL_LAT - TEMP_TC_LAT;
   localparam int HUM_DLY = TOTAL_LAT - TEMP_TF_LAT - HUM_LAT;

   // coefficient registers
   logic [47:0] temp_coef_ff;
   logic [63:0] press_lo_ff, press_hi_ff, hum_coef_ff;
   logic [15:0] press_p9_ff;

   // pipeline control: valid bits travel alongside the stage registers
   logic                 en;
   logic [TOTAL_LAT-1:0] vld_ff;

   // raw fields waiting for the fine temperature
   logic [19:0] rp_dly_ff [TEMP_TF_LAT];
   logic [15:0] rh_dly_ff [TEMP_TF_LAT];
   // finished temperature and humidity waiting for pressure
   logic [31:0] tc_dly_ff  [TC_DLY];
   logic [16:0] hum_dly_ff [HUM_DLY];

   logic [31:0] tf, tc, pressure;
   logic [16:0] humidity;
   logic        invalid;

   // csr writes, indexes past the list are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coef_ff <= '0;
         press_lo_ff  <= '0;
         press_hi_ff  <= '0;
         press_p9_ff  <= '0;
         hum_coef_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_TEMP_COEF: temp_coef_ff <= csr_data[47:0];
            CSR_PRESS_LO:  press_lo_ff  <= csr_data;
            CSR_PRESS_HI:  press_hi_ff  <= csr_data;
            CSR_PRESS_P9:  press_p9_ff  <= csr_data[15:0];
            CSR_HUM_COEF:  hum_coef_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // advance unless a finished result is stuck at the output
   assign en         = !vld_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rp_dly_ff[0]  <= req_tdata[39:20];
         rh_dly_ff[0]  <= req_tdata[55:40];
         for (int i = 1; i < TEMP_TF_LAT; i++) begin
            rp_dly_ff[i] <= rp_dly_ff[i-1];
            rh_dly_ff[i] <= rh_dly_ff[i-1];
         end
         tc_dly_ff[0]  <= tc;
         for (int i = 1; i < TC_DLY; i++) begin
            tc_dly_ff[i] <= tc_dly_ff[i-1];
         end
         hum_dly_ff[0] <= humidity;
         for (int i = 1; i < HUM_DLY; i++) begin
            hum_dly_ff[i] <= hum_dly_ff[i-1];
         end
      end
   end

   thp_temp u_temp (
      .clock           (clock),
      .en              (en),
      .raw_temperature (req_tdata[19:0]),
      .temp_coef       (temp_coef_ff),
      .tf              (tf),
      .tc              (tc)
   );

   thp_press u_press (
      .clock        (clock),
      .en           (en),
      .tf           (tf),
      .raw_pressure (rp_dly_ff[TEMP_TF_LAT-1]),
      .press_lo     (press_lo_ff),
      .press_hi     (press_hi_ff),
      .press_p9     (press_p9_ff),
      .pressure     (pressure),
      .invalid      (invalid)
   );

   thp_hum u_hum (
      .clock        (clock),
      .en           (en),
      .tf           (tf),
      .raw_humidity (rh_dly_ff[TEMP_TF_LAT-1]),
      .hum_coef     (hum_coef_ff),
      .humidity     (humidity)
   );

   assign rsp_tdata = {7'b0, hum_dly_ff[HUM_DLY-1], pressure, tc_dly_ff[TC_DLY-1]};
   assign rsp_tuser = invalid;

endmodule

`default_nettype wire

[hw/rtl/thp_checker.sv]
// ----------------------------------------------------------------------------
// thp_checker
// port-level checks of the compensation core
// ----------------------------------------------------------------------------
`default_nettype none

module thp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [55:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [87:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [2:0]  csr_index,
   input wire logic [63:0] csr_data
);

   // a held response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // a held response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response payload changed while stalled");

   // an empty output never blocks the request side
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side stalled with empty output");

   // zero divisor forces zero pressure
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[63:32] == 32'd0)
      else $error("invalid pressure not zero");

   // humidity stays within the clamp
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[80:64] <= 17'd102400 && rsp_tdata[87:81] == 7'd0)
      else $error("humidity out of range");

endmodule

bind thp_sensor_compensation_core thp_checker u_thp_checker (.*);

`default_nettype wire
